// ----- rtl/lsbp_pkg.sv -----
// ----------------------------------------------------------------------------
// lsbp_pkg
// Shared types and constants for the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lsbp_pkg;

	localparam int VALUE_W       = 64;  // field_value width
	localparam int WIDTH_W       = 7;   // field_width width
	localparam int TOTAL_W       = 40;  // total_bits width
	localparam int BYTE_W        = 8;
	localparam int PEND_W        = 3;   // pending bit count, 0..7
	localparam int S_TDATA_W     = 72;  // field_value + field_width, padded
	localparam int M_TDATA_W     = 48;  // out_byte + total_bits
	localparam int MAX_WIDTH_DEF = 64;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	// controls from the sequencer to the accumulator
	typedef struct packed {
		logic load;   // merge a new field above the pending bits
		logic flush;  // drop the pending count, byte goes out by shift
		logic shift;  // advance one byte
	} lsbp_ctl_t;

endpackage

// ----- rtl/lsb_first_bit_packer.sv -----
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs variable-width fields into a byte stream, least significant bit
// first, with a saturating running bit count on every byte.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                   | tuser / tlast
//  --------+-----+--------------------------------------+------------------
//  s_*     | in  | field_value[63:0], field_width[70:64] | tuser[0] = op
//  m_*     | out | out_byte[7:0], total_bits[47:8]      | tlast = is_last
//
//  An append merges the field, then produces each byte it completes (0 to 8)
//  in turn, each byte taken from the low end of the accumulator by the single
//  byte shifter. A flush with bits pending produces one byte.
//  s_tready is low while bytes are being produced; the output register lets
//  the next transaction in while the last byte still waits on m_tready.
//  A stall on m_tready holds the sequencer. Reset clears the pending bits,
//  the bit total and the output valid.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer #(
	parameter int MAX_WIDTH = lsbp_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lsbp_pkg::S_TDATA_W-1:0]  s_tdata,  // field_value, field_width, pad
	input  logic [0:0]                      s_tuser,  // op
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lsbp_pkg::M_TDATA_W-1:0]  m_tdata,  // out_byte, total_bits
	output logic                            m_tlast   // is_last
);

	localparam int BYTES_MAX = (MAX_WIDTH + lsbp_pkg::BYTE_W - 1) / lsbp_pkg::BYTE_W;
	localparam int CNT_W     = $clog2(BYTES_MAX + 1);
	localparam logic [lsbp_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                rem_q;     // bytes still to produce
	logic [lsbp_pkg::TOTAL_W-1:0]    total_q;

	logic                            op;
	logic [lsbp_pkg::WIDTH_W-1:0]    width_raw;
	logic [lsbp_pkg::WIDTH_W-1:0]    width_clamp;
	logic [lsbp_pkg::TOTAL_W:0]      total_sum;
	logic                            in_fire;
	logic                            out_free;
	lsbp_pkg::lsbp_ctl_t             ctl;
	logic [lsbp_pkg::BYTE_W-1:0]     low_byte;
	logic [CNT_W-1:0]                full_bytes;
	logic [lsbp_pkg::PEND_W-1:0]     pend_cnt;

	assign op        = s_tuser[0];
	assign width_raw = s_tdata[lsbp_pkg::VALUE_W +: lsbp_pkg::WIDTH_W];
	// clamp widths above the maximum
	assign width_clamp = (width_raw > lsbp_pkg::WIDTH_W'(MAX_WIDTH))
		? lsbp_pkg::WIDTH_W'(MAX_WIDTH) : width_raw;
	assign total_sum = {1'b0, total_q} + (lsbp_pkg::TOTAL_W+1)'(width_clamp);

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	// load only on appends that carry bits; flush on every flush request
	always_comb begin
		ctl.load  = in_fire && (op == lsbp_pkg::OP_APPEND) && (width_clamp != '0);
		ctl.flush = in_fire && (op == lsbp_pkg::OP_FLUSH);
		ctl.shift = (state_q == ST_EMIT) && out_free;
	end

	lsbp_acc #(
		.MAX_WIDTH (MAX_WIDTH),
		.CNT_W     (CNT_W)
	) u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.value      (s_tdata[MAX_WIDTH-1:0]),
		.width      (width_clamp),
		.low_byte   (low_byte),
		.full_bytes (full_bytes),
		.pend_cnt   (pend_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rem_q    <= '0;
			total_q  <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
					end
					if (ctl.load) begin
						// saturate the running total
						total_q <= total_sum[lsbp_pkg::TOTAL_W] ? TOTAL_MAX
							: total_sum[lsbp_pkg::TOTAL_W-1:0];
						rem_q   <= full_bytes;
						if (full_bytes != '0) begin
							state_q <= ST_EMIT;
						end
					end else if (ctl.flush && (pend_cnt != '0)) begin
						rem_q   <= CNT_W'(1);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {total_q, low_byte};
						m_tlast  <= (rem_q == CNT_W'(1));
						rem_q    <= rem_q - CNT_W'(1);
						if (rem_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/lsbp_acc.sv -----
// ----------------------------------------------------------------------------
// lsbp_acc
// Bit accumulator: merges a field above the pending bits, then gives
// bytes out of its low end through one shared shift-by-a-byte unit.
// ----------------------------------------------------------------------------
module lsbp_acc #(
	parameter int MAX_WIDTH = lsbp_pkg::MAX_WIDTH_DEF,
	parameter int CNT_W     = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lsbp_pkg::lsbp_ctl_t           ctl,
	input  logic [MAX_WIDTH-1:0]          value,
	input  logic [lsbp_pkg::WIDTH_W-1:0]  width,      // already clamped
	output logic [lsbp_pkg::BYTE_W-1:0]   low_byte,
	output logic [CNT_W-1:0]              full_bytes, // bytes a load completes
	output logic [lsbp_pkg::PEND_W-1:0]   pend_cnt
);

	localparam int ACC_W = MAX_WIDTH + lsbp_pkg::BYTE_W - 1;

	logic [ACC_W-1:0]                  acc_q;
	logic [lsbp_pkg::PEND_W-1:0]       cnt_q;
	logic [MAX_WIDTH-1:0]              masked;
	logic [lsbp_pkg::WIDTH_W:0]        sum;

	assign masked     = value & ~({MAX_WIDTH{1'b1}} << width);
	assign sum        = {1'b0, width} + (lsbp_pkg::WIDTH_W+1)'(cnt_q);
	assign full_bytes = CNT_W'(sum >> 3);
	assign low_byte   = acc_q[lsbp_pkg::BYTE_W-1:0];
	assign pend_cnt   = cnt_q;

	// upper bits above the pending ones are always zero between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			if (ctl.load) begin
				acc_q <= acc_q | (ACC_W'(masked) << cnt_q);
				cnt_q <= sum[lsbp_pkg::PEND_W-1:0];
			end else if (ctl.shift) begin
				acc_q <= acc_q >> lsbp_pkg::BYTE_W;
			end
			if (ctl.flush) begin
				cnt_q <= '0;
			end
		end
	end

endmodule
